// ===== rtl/core/lsrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LED strip rainbow pattern block.
package lsrp_pkg;

    localparam int unsigned MaxLedsDefault = 256;

    localparam int unsigned IdxW   = 8;
    localparam int unsigned CountW = 9;
    localparam int unsigned ChanW  = 8;
    localparam int unsigned HueW   = 17;
    localparam int unsigned NumW   = 25;
    localparam int unsigned TW     = 14;

    localparam logic [HueW-1:0]   HueFull    = 17'd92160;
    localparam logic [HueW-1:0]   HueSector  = 17'd15360;
    localparam logic [CountW-1:0] OffsetStep = 9'd2;
    localparam logic [CountW-1:0] OffsetWrap = 9'd360;
    localparam logic [CountW-1:0] CountReset = 9'd24;
    localparam logic [4:0]        RampMul    = 5'd17;
    localparam logic [ChanW-1:0]  ChanFull   = 8'd255;

    localparam int unsigned DivSteps = HueW;
    localparam int unsigned StepCntW = $clog2(DivSteps);

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_NAV     = 2'd1,
        MODE_RAINBOW = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic {
        REG_PATTERN_MODE = 1'b0,
        REG_LED_COUNT    = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_HUE,
        ST_SECT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic hue_load;
        logic sect_load;
        logic out_load;
    } t_cmd;

endpackage

// ===== rtl/core/lsrp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one transaction through the datapath and owns the output valid flag.
module lsrp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lsrp_pkg::t_cmd o_cmd
);
    import lsrp_pkg::*;

    t_state                r_state, n_state;
    logic [StepCntW-1:0]   r_step, n_step;
    logic                  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == StepCntW'(DivSteps - 1)) begin
                    n_state = ST_HUE;
                end
            end
            ST_HUE: begin
                o_cmd.hue_load = 1'b1;
                n_state        = ST_SECT;
            end
            ST_SECT: begin
                o_cmd.sect_load = 1'b1;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/lsrp_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration, hue offset, serial hue divider, sector ramp and output register.
module lsrp_dp #(
    parameter int unsigned MAX_LEDS = lsrp_pkg::MaxLedsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsrp_pkg::t_cmd               i_cmd,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [lsrp_pkg::CountW-1:0]  i_cfg_data,
    input  logic [lsrp_pkg::IdxW-1:0]    i_led_index,
    input  logic                         i_end_of_frame,
    output logic [lsrp_pkg::ChanW-1:0]   o_red,
    output logic [lsrp_pkg::ChanW-1:0]   o_green,
    output logic [lsrp_pkg::ChanW-1:0]   o_blue,
    output logic [lsrp_pkg::ChanW-1:0]   o_white
);
    import lsrp_pkg::*;

    localparam logic [CountW-1:0] CountCap =
        (MAX_LEDS < 256) ? CountW'(MAX_LEDS) : CountW'(256);

    t_mode               r_mode;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   r_offset;

    logic [IdxW-1:0]     r_idx;
    logic                r_eof;
    logic [CountW-1:0]   r_n;
    logic [CountW-1:0]   r_rem;
    logic [HueW-1:0]     r_qn;
    logic [HueW-1:0]     r_hue;
    logic [2:0]          r_sector;
    logic [TW:0]         r_ramp;
    logic [ChanW-1:0]    r_red, r_green, r_blue;

    logic [CountW-1:0]   eff_count;
    logic [NumW-1:0]     num;
    logic [CountW:0]     trial;
    logic                trial_ge;
    logic [HueW:0]       hue_sum;
    logic [2:0]          sector;
    logic [HueW-1:0]     sector_base;
    logic [TW-1:0]       t_pos;
    logic [19:0]         ramp_prod;
    logic [ChanW-1:0]    x;
    logic [CountW:0]     off_next;
    logic [ChanW-1:0]    n_red, n_green, n_blue;

    always_comb begin
        if (r_count == '0) begin
            eff_count = CountW'(1);
        end else if (r_count > CountCap) begin
            eff_count = CountCap;
        end else begin
            eff_count = r_count;
        end
    end

    assign num      = NumW'(i_led_index) * NumW'(HueFull);
    assign trial    = {r_rem, r_qn[HueW-1]};
    assign trial_ge = trial >= {1'b0, r_n};
    assign hue_sum  = {1'b0, r_qn} + {1'b0, r_offset, 8'd0};

    always_comb begin
        if (r_hue >= 5 * HueSector) begin
            sector = 3'd5;
        end else if (r_hue >= 4 * HueSector) begin
            sector = 3'd4;
        end else if (r_hue >= 3 * HueSector) begin
            sector = 3'd3;
        end else if (r_hue >= 2 * HueSector) begin
            sector = 3'd2;
        end else if (r_hue >= HueSector) begin
            sector = 3'd1;
        end else begin
            sector = 3'd0;
        end
        sector_base = HueW'(sector) * HueSector;
        t_pos       = TW'(r_hue - sector_base);
    end

    assign ramp_prod = 20'(r_ramp) * 20'(RampMul);
    assign x         = ramp_prod[17:10];
    assign off_next  = {1'b0, r_offset} + {1'b0, OffsetStep};

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        if ({1'b0, r_idx} < r_n) begin
            case (r_mode)
                MODE_NAV: begin
                    if ({1'b0, r_idx} < (r_n >> 1)) begin
                        n_green = ChanFull;
                    end else begin
                        n_red = ChanFull;
                    end
                end
                MODE_RAINBOW: begin
                    case (r_sector)
                        3'd0: begin
                            n_red = ChanFull; n_green = x;
                        end
                        3'd1: begin
                            n_red = x; n_green = ChanFull;
                        end
                        3'd2: begin
                            n_green = ChanFull; n_blue = x;
                        end
                        3'd3: begin
                            n_green = x; n_blue = ChanFull;
                        end
                        3'd4: begin
                            n_red = x; n_blue = ChanFull;
                        end
                        default: begin
                            n_red = ChanFull; n_blue = x;
                        end
                    endcase
                end
                default: begin
                    n_red = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_count  <= CountReset;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_PATTERN_MODE: begin
                    r_mode   <= t_mode'(i_cfg_data[1:0]);
                    r_offset <= '0;
                end
                REG_LED_COUNT: begin
                    r_count <= i_cfg_data;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end else if (i_cmd.out_load && r_eof) begin
            if (off_next >= {1'b0, OffsetWrap}) begin
                r_offset <= CountW'(off_next - {1'b0, OffsetWrap});
            end else begin
                r_offset <= CountW'(off_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_led_index;
            r_eof <= i_end_of_frame;
            r_n   <= eff_count;
            r_rem <= CountW'(num[NumW-1:HueW]);
            r_qn  <= num[HueW-1:0];
        end
        if (i_cmd.div_step) begin
            if (trial_ge) begin
                r_rem <= CountW'(trial - {1'b0, r_n});
            end else begin
                r_rem <= CountW'(trial);
            end
            r_qn <= {r_qn[HueW-2:0], trial_ge};
        end
        if (i_cmd.hue_load) begin
            if (hue_sum >= {1'b0, HueFull}) begin
                r_hue <= HueW'(hue_sum - {1'b0, HueFull});
            end else begin
                r_hue <= HueW'(hue_sum);
            end
        end
        if (i_cmd.sect_load) begin
            r_sector <= sector;
            if (sector[0]) begin
                r_ramp <= (TW+1)'(HueSector) - {1'b0, t_pos};
            end else begin
                r_ramp <= {1'b0, t_pos};
            end
        end
        if (i_cmd.out_load) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_white = '0;

endmodule

// ===== rtl/core/led_strip_rainbow_pattern.sv =====
`timescale 1ns / 1ps
// Top level: LED strip colour pattern generator (off, nav lights, rotating rainbow).
// Each transaction takes one LED index and returns its RGBW colour. It passes a load
// step, the bit-serial divider that places the LED on the hue circle (index*360/count,
// in 1/256 degree units), the hue offset add, the sector split and the ramp multiply
// into the output register. No new index is taken before that, but one is taken while
// the previous result waits on the output side. Configuration writes are to be made
// only while the block is idle; the block itself does not enforce this. Writing
// pattern_mode clears the rainbow offset. White is always zero.
module led_strip_rainbow_pattern #(
    parameter int unsigned MAX_LEDS = lsrp_pkg::MaxLedsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [lsrp_pkg::CountW-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lsrp_pkg::IdxW-1:0]    i_led_index,
    input  logic                         i_end_of_frame,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lsrp_pkg::ChanW-1:0]   o_red,
    output logic [lsrp_pkg::ChanW-1:0]   o_green,
    output logic [lsrp_pkg::ChanW-1:0]   o_blue,
    output logic [lsrp_pkg::ChanW-1:0]   o_white
);
    import lsrp_pkg::*;

    t_cmd cmd;

    lsrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    lsrp_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_led_index    (i_led_index),
        .i_end_of_frame (i_end_of_frame),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_white        (o_white)
    );

endmodule

// ===== tb/sv/led_strip_rainbow_pattern_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LED strip pattern generator, with a pixel colour scoreboard.
module led_strip_rainbow_pattern_tb;
    import lsrp_pkg::*;

    localparam int unsigned HueTurn      = 92160;
    localparam int unsigned HueSixth     = 15360;
    localparam int unsigned StripMax     = 256;
    localparam int unsigned IdleLimit    = 2000;
    localparam int unsigned SettleCycles = 30;
    localparam int unsigned HoldCycles   = 400;
    localparam int unsigned GapMax       = 18;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] white;
    } t_colour;

    class pixel_scoreboard;
        t_mode             mode;
        logic [CountW-1:0] count_reg;
        int unsigned       offset_deg;
        t_colour           pixels_due[$];
        int unsigned       n_errors;

        function new();
            mode       = MODE_OFF;
            count_reg  = 9'd24;
            offset_deg = 0;
            n_errors   = 0;
        endfunction

        function void apply_write(t_reg_index r, logic [CountW-1:0] word);
            if (r == REG_PATTERN_MODE) begin
                mode       = t_mode'(word[1:0]);
                offset_deg = 0;
            end else begin
                count_reg = word;
            end
        endfunction

        function int unsigned strip_length();
            if (count_reg == 0) return 1;
            if (count_reg > StripMax) return StripMax;
            return 32'(count_reg);
        endfunction

        function t_colour colour_of(logic [IdxW-1:0] idx);
            int unsigned n, pos, hue, sector, frac, ramp;
            t_colour c;
            c   = '0;
            n   = strip_length();
            pos = 32'(idx);
            if (pos < n) begin
                if (mode == MODE_NAV) begin
                    if (pos < n / 2) c.green = 8'hFF;
                    else c.red = 8'hFF;
                end else if (mode == MODE_RAINBOW) begin
                    hue    = ((pos * HueTurn) / n + offset_deg * 256) % HueTurn;
                    sector = hue / HueSixth;
                    frac   = hue % HueSixth;
                    if (sector % 2 == 0) ramp = (frac * 255) / HueSixth;
                    else ramp = ((HueSixth - frac) * 255) / HueSixth;
                    case (sector)
                        0: begin
                            c.red = 8'hFF; c.green = 8'(ramp);
                        end
                        1: begin
                            c.red = 8'(ramp); c.green = 8'hFF;
                        end
                        2: begin
                            c.green = 8'hFF; c.blue = 8'(ramp);
                        end
                        3: begin
                            c.green = 8'(ramp); c.blue = 8'hFF;
                        end
                        4: begin
                            c.red = 8'(ramp); c.blue = 8'hFF;
                        end
                        default: begin
                            c.red = 8'hFF; c.blue = 8'(ramp);
                        end
                    endcase
                end
            end
            return c;
        endfunction

        function void note_request(logic [IdxW-1:0] idx, logic eof);
            pixels_due.push_back(colour_of(idx));
            if (eof) begin
                offset_deg = offset_deg + 2;
                if (offset_deg >= 360) offset_deg = offset_deg - 360;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            n_errors++;
        endtask

        task check_pixel(t_colour got);
            t_colour want;
            if (pixels_due.size() == 0) begin
                report($sformatf("unexpected pixel r=%0d g=%0d b=%0d w=%0d",
                                 got.red, got.green, got.blue, got.white));
            end else begin
                want = pixels_due.pop_front();
                if (got.red !== want.red)
                    report($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report($sformatf("blue %0d, want %0d", got.blue, want.blue));
                if (got.white !== want.white)
                    report($sformatf("white %0d, want %0d", got.white, want.white));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    t_reg_index        cfg_index;
    logic [CountW-1:0] cfg_data;
    logic              in_valid;
    logic              o_in_ready;
    logic [IdxW-1:0]   led_index;
    logic              end_of_frame;
    logic              o_out_valid;
    logic              out_ready;
    logic [ChanW-1:0]  o_red;
    logic [ChanW-1:0]  o_green;
    logic [ChanW-1:0]  o_blue;
    logic [ChanW-1:0]  o_white;

    bit                hold_req;
    bit                tx_calm;
    bit                rx_calm;
    int unsigned       idle_cycles;
    pixel_scoreboard   sb;

    led_strip_rainbow_pattern dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_led_index    (led_index),
        .i_end_of_frame (end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_white        (o_white)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("led_strip_rainbow_pattern_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, GapMax);
            if (hold_req) begin
                stall    = HoldCycles;
                hold_req = 1'b0;
            end
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
            sb.check_pixel('{o_red, o_green, o_blue, o_white});
        end
    end

    task automatic send_item(input logic [IdxW-1:0] idx, input logic eof);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, GapMax);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        led_index    <= idx;
        end_of_frame <= eof;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        sb.note_request(idx, eof);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_register(input t_reg_index r, input logic [CountW-1:0] word);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= word;
        sb.apply_write(r, word);
    endtask

    task automatic apply_settings(input bit set_mode, input logic [CountW-1:0] mode_word,
                                  input bit set_count, input logic [CountW-1:0] count_word);
        settle();
        if (set_mode) write_register(REG_PATTERN_MODE, mode_word);
        if (set_count) write_register(REG_LED_COUNT, count_word);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(input int unsigned n, input int unsigned eof_pct,
                                 input int unsigned in_pct, input bit hold,
                                 input bit pause_mid, input bit calm);
        int unsigned     n_eff;
        logic [IdxW-1:0] idx;
        logic            eof;
        tx_calm = calm || ($urandom_range(0, 3) == 0);
        rx_calm = calm || ($urandom_range(0, 3) == 0);
        if (hold) hold_req = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2) settle();
            n_eff = sb.strip_length();
            if ($urandom_range(0, 99) < in_pct) idx = IdxW'($urandom_range(0, n_eff - 1));
            else idx = IdxW'($urandom_range(0, 255));
            eof = ($urandom_range(0, 99) < eof_pct);
            send_item(idx, eof);
        end
    endtask

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_PATTERN_MODE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        led_index    = '0;
        end_of_frame = 1'b0;
        out_ready    = 1'b0;
        hold_req     = 1'b0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        idle_cycles  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: off, 24 LEDs
        send_item(8'd0, 1'b0);
        send_item(8'd23, 1'b0);
        send_item(8'd24, 1'b0);
        send_item(8'd255, 1'b1);
        random_pixels(60, 20, 80, 0, 0, 0);

        apply_settings(1, 9'(MODE_RAINBOW), 1, 9'd256);
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd128, 1'b1);
        send_item(8'd43, 1'b0);
        random_pixels(150, 30, 70, 0, 0, 1);

        // count alone: offset carries over, oversize count saturates
        apply_settings(0, '0, 1, 9'd300);
        random_pixels(80, 25, 60, 0, 0, 0);

        apply_settings(0, '0, 1, 9'd0);
        send_item(8'd0, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd255, 1'b1);
        random_pixels(40, 20, 50, 0, 0, 0);

        apply_settings(1, 9'(MODE_NAV), 1, 9'd24);
        send_item(8'd11, 1'b0);
        send_item(8'd12, 1'b1);
        send_item(8'd23, 1'b0);
        send_item(8'd24, 1'b1);
        random_pixels(80, 20, 80, 0, 0, 0);

        apply_settings(0, '0, 1, 9'd1);
        send_item(8'd0, 1'b1);
        random_pixels(30, 20, 60, 0, 0, 0);

        apply_settings(1, 9'h1FF, 0, '0);
        send_item(8'd0, 1'b0);
        send_item(8'd5, 1'b1);
        random_pixels(40, 20, 60, 0, 0, 0);

        apply_settings(1, 9'(MODE_OFF), 1, 9'd511);
        random_pixels(60, 20, 60, 1, 0, 0);

        // long eof run to wrap the offset past 360
        apply_settings(1, 9'(MODE_RAINBOW), 1, 9'd3);
        random_pixels(300, 90, 85, 0, 0, 0);

        apply_settings(1, {7'h7F, MODE_RAINBOW}, 1, 9'd255);
        random_pixels(150, 25, 85, 1, 0, 0);

        apply_settings(1, 9'(MODE_NAV), 1, 9'd2);
        random_pixels(40, 20, 70, 0, 1, 0);

        settle();
        if (sb.n_errors == 0 && sb.pixels_due.size() == 0) begin
            $display("led_strip_rainbow_pattern_tb: PASS");
        end else begin
            $display("led_strip_rainbow_pattern_tb: FAIL");
        end
        $finish;
    end

endmodule
